FILE: src/e2i_pkg.sv
// shared types, codes and format tables for the extended-to-ieee converter
// no dependencies; imported by every module of the block
package e2i_pkg;

  // target format select
  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_DOUBLE = 2'd1,
    OP_QUAD   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic [14:0] SrcExpBias = 15'd16383;
  localparam logic [14:0] ExpAllOnes = 15'h7fff;
  localparam int unsigned SingleFracBits = 23;
  localparam int unsigned DoubleFracBits = 52;

  // input word as it enters the pipe
  typedef struct packed {
    logic [1:0]  operation;
    logic        sign;
    logic [14:0] exponent;
    logic [63:0] significand;
  } in_word_t;

  // after stage 1: per-byte leading-zero data
  typedef struct packed {
    logic [1:0]      operation;
    logic            sign;
    logic [14:0]     exponent;
    logic [63:0]     significand;
    logic            exp_ones;
    logic            sig_zero;
    logic [7:0]      byte_nz;
    logic [7:0][2:0] byte_lz;
  } s1_word_t;

  // after stage 2: coarse-shifted significand and full count
  typedef struct packed {
    logic [1:0]  operation;
    logic        sign;
    logic [14:0] exponent;
    logic [63:0] sig_coarse;
    logic [2:0]  fine;
    logic [5:0]  lz;
    logic        exp_ones;
    logic        sig_zero;
  } s2_word_t;

  // result word
  typedef struct packed {
    logic        sign;
    logic [14:0] exponent;
    logic [63:0] fraction;
    logic        low_fill;
    logic [1:0]  status;
  } out_word_t;

  // leading zeros of one byte
  function automatic logic [2:0] lzc8(input logic [7:0] b);
    logic [2:0] n;
    logic       done;
    n    = 3'd0;
    done = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!done) begin
        if (b[i]) begin
          done = 1'b1;
        end else if (i > 0) begin
          n = n + 3'd1;
        end
      end
    end
    return n;
  endfunction

  // target exponent bias
  function automatic logic [14:0] fmt_bias(input logic [1:0] op);
    logic [14:0] r;
    unique case (op) inside
      OP_SINGLE: r = 15'd127;
      OP_DOUBLE: r = 15'd1023;
      default:   r = 15'd16383;
    endcase
    return r;
  endfunction

  // target all-ones exponent
  function automatic logic [14:0] fmt_exp_max(input logic [1:0] op);
    logic [14:0] r;
    unique case (op) inside
      OP_SINGLE: r = 15'h00ff;
      OP_DOUBLE: r = 15'h07ff;
      default:   r = 15'h7fff;
    endcase
    return r;
  endfunction

endpackage

FILE: src/extended_to_ieee_format_convert.sv
// top level of the extended-to-ieee converter: three pipeline stages
// depends on e2i_pkg, e2i_lzc_stage, e2i_shift_stage, e2i_pack_stage
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------------
//   input   | in_valid/in_stall  | operation, sign_in, exponent_in, significand_in
//   output  | out_valid/out_stall| sign_out, exponent_out, fraction_out,
//           |                    | quad_low_fill, status
//
// one word enters per cycle while in_stall is low; a word passes through the three stage
// registers (byte count, coarse shift, fine shift and pack).
// reset is synchronous and empties the pipe; no clearing pass.
// a stall at the output holds the last stage; earlier stages keep moving into
// empty slots, so in_stall rises only when every stage holds a word.
module extended_to_ieee_format_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic        sign_in,
  input  logic [14:0] exponent_in,
  input  logic [63:0] significand_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sign_out,
  output logic [14:0] exponent_out,
  output logic [63:0] fraction_out,
  output logic        quad_low_fill,
  output logic [1:0]  status
);
  import e2i_pkg::*;

  in_word_t  in_word;
  s1_word_t  s1_word;
  s2_word_t  s2_word;
  out_word_t out_word;
  logic      s1_valid;
  logic      s1_stall;
  logic      s2_valid;
  logic      s2_stall;

  assign in_word.operation   = operation;
  assign in_word.sign        = sign_in;
  assign in_word.exponent    = exponent_in;
  assign in_word.significand = significand_in;

  // stage 1
  e2i_lzc_stage u_lzc (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_data    (in_word),
    .up_stall   (in_stall),
    .down_valid (s1_valid),
    .down_data  (s1_word),
    .down_stall (s1_stall)
  );

  // stage 2
  e2i_shift_stage u_shift (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_data    (s1_word),
    .up_stall   (s1_stall),
    .down_valid (s2_valid),
    .down_data  (s2_word),
    .down_stall (s2_stall)
  );

  // stage 3
  e2i_pack_stage u_pack (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s2_valid),
    .up_data    (s2_word),
    .up_stall   (s2_stall),
    .down_valid (out_valid),
    .down_data  (out_word),
    .down_stall (out_stall)
  );

  assign sign_out      = out_word.sign;
  assign exponent_out  = out_word.exponent;
  assign fraction_out  = out_word.fraction;
  assign quad_low_fill = out_word.low_fill;
  assign status        = out_word.status;

endmodule

FILE: src/e2i_lzc_stage.sv
// stage 1: special-case decode and per-byte leading-zero count
// depends on e2i_pkg
module e2i_lzc_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  e2i_pkg::in_word_t up_data,
  output logic              up_stall,
  output logic              down_valid,
  output e2i_pkg::s1_word_t down_data,
  input  logic              down_stall
);
  import e2i_pkg::*;

  logic     valid;
  s1_word_t data;
  s1_word_t data_next;
  logic     load;

  assign load     = !valid || !down_stall;
  assign up_stall = !load;

  // byte flags and counts
  always_comb begin
    data_next.operation   = up_data.operation;
    data_next.sign        = up_data.sign;
    data_next.exponent    = up_data.exponent;
    data_next.significand = up_data.significand;
    data_next.exp_ones    = (up_data.exponent == ExpAllOnes);
    data_next.sig_zero    = (up_data.significand == 64'd0);
    for (int i = 0; i < 8; i++) begin
      data_next.byte_nz[i] = |up_data.significand[i*8 +: 8];
      data_next.byte_lz[i] = lzc8(up_data.significand[i*8 +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

FILE: src/e2i_shift_stage.sv
// stage 2: pick the leading byte, full count and coarse byte shift
// depends on e2i_pkg
module e2i_shift_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  e2i_pkg::s1_word_t up_data,
  output logic              up_stall,
  output logic              down_valid,
  output e2i_pkg::s2_word_t down_data,
  input  logic              down_stall
);
  import e2i_pkg::*;

  logic     valid;
  s2_word_t data;
  s2_word_t data_next;
  logic     load;
  logic [2:0] hi;
  logic [2:0] coarse;

  assign load     = !valid || !down_stall;
  assign up_stall = !load;

  // highest nonzero byte sets the coarse shift
  always_comb begin
    hi = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (up_data.byte_nz[i]) hi = 3'(i);
    end
    coarse = 3'd7 - hi;
    data_next.operation  = up_data.operation;
    data_next.sign       = up_data.sign;
    data_next.exponent   = up_data.exponent;
    data_next.sig_coarse = up_data.significand << {coarse, 3'b000};
    data_next.fine       = up_data.byte_lz[hi];
    data_next.lz         = {coarse, up_data.byte_lz[hi]};
    data_next.exp_ones   = up_data.exp_ones;
    data_next.sig_zero   = up_data.sig_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

FILE: src/e2i_pack_stage.sv
// stage 3: fine shift, exponent rebias, range check and result packing
// depends on e2i_pkg
module e2i_pack_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  input  e2i_pkg::s2_word_t  up_data,
  output logic               up_stall,
  output logic               down_valid,
  output e2i_pkg::out_word_t down_data,
  input  logic               down_stall
);
  import e2i_pkg::*;

  logic        valid;
  out_word_t   data;
  out_word_t   data_next;
  logic        load;
  logic [63:0] aligned;
  logic [63:0] frac_fmt;
  logic [63:0] frac_all;
  logic [14:0] exp_max;
  logic        is_quad;
  logic signed [16:0] t;

  assign load     = !valid || !down_stall;
  assign up_stall = !load;

  // normalize, rebias and classify
  always_comb begin
    exp_max = fmt_exp_max(up_data.operation);
    is_quad = (up_data.operation == OP_QUAD) || (up_data.operation == OP_RSVD);
    // drop the leading one and left-align the rest
    aligned = (up_data.sig_coarse << up_data.fine) << 1;
    t = $signed({2'b00, up_data.exponent}) + $signed({2'b00, fmt_bias(up_data.operation)})
        - $signed({2'b00, SrcExpBias}) - $signed({11'd0, up_data.lz});
    case (up_data.operation)
      OP_SINGLE: begin
        frac_fmt = {41'd0, aligned[63 -: SingleFracBits]};
        frac_all = {41'd0, {SingleFracBits{1'b1}}};
      end
      OP_DOUBLE: begin
        frac_fmt = {12'd0, aligned[63 -: DoubleFracBits]};
        frac_all = {12'd0, {DoubleFracBits{1'b1}}};
      end
      default: begin
        frac_fmt = aligned;
        frac_all = '1;
      end
    endcase

    data_next.sign     = up_data.sign;
    data_next.exponent = 15'd0;
    data_next.fraction = 64'd0;
    data_next.low_fill = 1'b0;
    data_next.status   = ST_OK;
    if (up_data.exp_ones) begin
      // infinity or nan
      data_next.exponent = exp_max;
      if (!up_data.sig_zero) begin
        data_next.fraction = frac_all;
        data_next.low_fill = is_quad;
      end
    end else if (!up_data.sig_zero) begin
      if (t >= $signed({2'b00, exp_max})) begin
        data_next.exponent = exp_max;
        data_next.status   = ST_OVER;
      end else if (t <= 17'sd0) begin
        data_next.status = ST_UNDER;
      end else begin
        data_next.exponent = t[14:0];
        data_next.fraction = frac_fmt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

FILE: src/e2i_checker.sv
// port-level checks for the extended-to-ieee converter, bound to the top level
// depends on e2i_pkg and extended_to_ieee_format_convert
module e2i_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        sign_out,
  input logic [14:0] exponent_out,
  input logic [63:0] fraction_out,
  input logic        quad_low_fill,
  input logic [1:0]  status
);
  import e2i_pkg::*;

  // pipe is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // held word stays put under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fraction_out)
      && $stable(exponent_out) && $stable(status) && $stable(sign_out))
    else $error("stalled output word changed");

  // overflow gives a clean infinity
  a_over_inf: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVER |-> fraction_out == 64'd0 && !quad_low_fill
      && exponent_out != 15'd0)
    else $error("overflow result is not infinity");

  // underflow gives a clean zero
  a_under_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDER |-> fraction_out == 64'd0 && exponent_out == 15'd0
      && !quad_low_fill)
    else $error("underflow result is not zero");

  // low fill only on a quad nan
  a_fill_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid && quad_low_fill |-> exponent_out == ExpAllOnes && fraction_out == '1
      && status == ST_OK)
    else $error("low fill set outside a quad nan");

endmodule

bind extended_to_ieee_format_convert e2i_checker u_e2i_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .sign_out      (sign_out),
  .exponent_out  (exponent_out),
  .fraction_out  (fraction_out),
  .quad_low_fill (quad_low_fill),
  .status        (status)
);

FILE: tb/extended_to_ieee_format_convert_tb.sv
// self-checking testbench for extended_to_ieee_format_convert: a directed table, then random words
// with random idling on both channels, checked against row results or an in-bench conversion model
// depends on e2i_pkg and the extended_to_ieee_format_convert rtl
module extended_to_ieee_format_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2i_pkg::*;

  localparam int ItemCount = 1050;

  // one directed stimulus row; typed rows carry their expected result
  typedef struct packed {
    op_t         op;
    logic        sgn;
    logic [14:0] exp;
    logic [63:0] sig;
    logic        typed;
    out_word_t   res;
  } dir_row_t;

  localparam int DirCount = 24;
  localparam dir_row_t DirectedRows [DirCount] = '{
    // infinity or nan in every format
    '{OP_SINGLE, 1'b0, 15'h7fff, 64'h0, 1'b1, '{1'b0, 15'h00ff, 64'h0, 1'b0, ST_OK}},
    '{OP_DOUBLE, 1'b1, 15'h7fff, 64'h1, 1'b1,
      '{1'b1, 15'h07ff, 64'h000f_ffff_ffff_ffff, 1'b0, ST_OK}},
    '{OP_QUAD, 1'b0, 15'h7fff, 64'hffff_ffff_ffff_ffff, 1'b1,
      '{1'b0, 15'h7fff, 64'hffff_ffff_ffff_ffff, 1'b1, ST_OK}},
    '{OP_RSVD, 1'b1, 15'h7fff, 64'h0, 1'b1, '{1'b1, 15'h7fff, 64'h0, 1'b0, ST_OK}},
    '{OP_SINGLE, 1'b0, 15'h7fff, 64'h1, 1'b1,
      '{1'b0, 15'h00ff, 64'h0000_0000_007f_ffff, 1'b0, ST_OK}},
    // signed zeros
    '{OP_SINGLE, 1'b1, 15'h3fff, 64'h0, 1'b1, '{1'b1, 15'h0, 64'h0, 1'b0, ST_OK}},
    '{OP_QUAD, 1'b0, 15'h0, 64'h0, 1'b1, '{1'b0, 15'h0, 64'h0, 1'b0, ST_OK}},
    '{OP_DOUBLE, 1'b0, 15'h1234, 64'h0, 1'b1, '{1'b0, 15'h0, 64'h0, 1'b0, ST_OK}},
    // one point zero
    '{OP_SINGLE, 1'b0, 15'h3fff, 64'h8000_0000_0000_0000, 1'b1,
      '{1'b0, 15'h007f, 64'h0, 1'b0, ST_OK}},
    '{OP_DOUBLE, 1'b1, 15'h3fff, 64'h8000_0000_0000_0000, 1'b1,
      '{1'b1, 15'h03ff, 64'h0, 1'b0, ST_OK}},
    '{OP_QUAD, 1'b0, 15'h3fff, 64'h8000_0000_0000_0000, 1'b1,
      '{1'b0, 15'h3fff, 64'h0, 1'b0, ST_OK}},
    // exponent overflow
    '{OP_SINGLE, 1'b0, 15'h7ffe, 64'hffff_ffff_ffff_ffff, 1'b1,
      '{1'b0, 15'h00ff, 64'h0, 1'b0, ST_OVER}},
    '{OP_DOUBLE, 1'b1, 15'h43ff, 64'h8000_0000_0000_0000, 1'b1,
      '{1'b1, 15'h07ff, 64'h0, 1'b0, ST_OVER}},
    '{OP_DOUBLE, 1'b0, 15'h43fe, 64'hffff_ffff_ffff_ffff, 1'b0, '0},
    // exponent underflow
    '{OP_QUAD, 1'b0, 15'h0, 64'h8000_0000_0000_0000, 1'b1,
      '{1'b0, 15'h0, 64'h0, 1'b0, ST_UNDER}},
    '{OP_QUAD, 1'b1, 15'h0, 64'h1, 1'b1, '{1'b1, 15'h0, 64'h0, 1'b0, ST_UNDER}},
    '{OP_SINGLE, 1'b0, 15'h3f80, 64'h8000_0000_0000_0000, 1'b1,
      '{1'b0, 15'h0, 64'h0, 1'b0, ST_UNDER}},
    '{OP_SINGLE, 1'b1, 15'h3f81, 64'hc000_0000_0000_0000, 1'b0, '0},
    // unnormals, lone integer bit, top of the quad range
    '{OP_QUAD, 1'b0, 15'h4000, 64'h1, 1'b0, '0},
    '{OP_DOUBLE, 1'b0, 15'h3c01, 64'h4000_0000_0000_0000, 1'b0, '0},
    '{OP_DOUBLE, 1'b0, 15'h3fff, 64'h1, 1'b0, '0},
    '{OP_SINGLE, 1'b0, 15'h3fff, 64'h7fff_ffff_ffff_ffff, 1'b0, '0},
    '{OP_QUAD, 1'b1, 15'h7ffe, 64'hffff_ffff_ffff_ffff, 1'b0, '0},
    '{OP_RSVD, 1'b0, 15'h5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_SINGLE;
  logic        sign_in = 1'b0;
  logic [14:0] exponent_in = '0;
  logic [63:0] significand_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        sign_out;
  logic [14:0] exponent_out;
  logic [63:0] fraction_out;
  logic        quad_low_fill;
  logic [1:0]  status;

  out_word_t pending_results [$];
  int        error_count = 0;

  extended_to_ieee_format_convert dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .sign_in        (sign_in),
    .exponent_in    (exponent_in),
    .significand_in (significand_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sign_out       (sign_out),
    .exponent_out   (exponent_out),
    .fraction_out   (fraction_out),
    .quad_low_fill  (quad_low_fill),
    .status         (status)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // conversion of one extended value to the selected ieee format
  function automatic out_word_t convert_extended(input op_t op, input logic sgn,
                                                 input logic [14:0] e,
                                                 input logic [63:0] sig);
    out_word_t   r;
    int unsigned fbits;
    int          tbias;
    logic [14:0] emax;
    logic [63:0] frac_ones;
    logic [63:0] aligned;
    int          lead;
    int          t;
    case (op)
      OP_SINGLE: begin
        fbits = SingleFracBits;
        tbias = 127;
        emax  = 15'h00ff;
      end
      OP_DOUBLE: begin
        fbits = DoubleFracBits;
        tbias = 1023;
        emax  = 15'h07ff;
      end
      default: begin
        fbits = 64;
        tbias = 16383;
        emax  = 15'h7fff;
      end
    endcase
    frac_ones = (fbits == 64) ? '1 : ((64'd1 << fbits) - 64'd1);
    r = '0;
    r.sign = sgn;
    r.status = ST_OK;
    if (e == ExpAllOnes) begin
      // infinity or nan
      r.exponent = emax;
      if (sig != '0) begin
        r.fraction = frac_ones;
        r.low_fill = (fbits == 64);
      end
    end else if (sig != '0) begin
      // normalize on the leading one and rebias
      lead = 0;
      while (!sig[63 - lead]) lead++;
      t = int'(e) - int'(SrcExpBias) + tbias - lead;
      if (t >= int'(emax)) begin
        r.exponent = emax;
        r.status = ST_OVER;
      end else if (t <= 0) begin
        r.status = ST_UNDER;
      end else begin
        aligned = (lead >= 63) ? 64'd0 : (sig << (lead + 1));
        r.exponent = t[14:0];
        r.fraction = (fbits == 64) ? aligned : (aligned >> (64 - fbits));
      end
    end
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(input op_t op, input logic sgn, input logic [14:0] e,
                           input logic [63:0] sig, input out_word_t want);
    in_valid       <= 1'b1;
    operation      <= op;
    sign_in        <= sgn;
    exponent_in    <= e;
    significand_in <= sig;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(want);
  endtask

  // optional gap after a word
  task automatic idle_sender(input bit smooth);
    int n;
    n = smooth ? 0 : next_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every expected word has come back
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // output stall pattern: stall bursts between free stretches
  initial begin : stall_gen
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = next_gap();
      if (n == 0) n = 1;
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
      out_stall <= 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
  end

  // compare each delivered word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: sign %0b exp %h frac %h",
               sign_out, exponent_out, fraction_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (sign_out !== want.sign) begin
          $error("sign_out: expected %0b, got %0b", want.sign, sign_out);
          error_count++;
        end
        if (exponent_out !== want.exponent) begin
          $error("exponent_out: expected %h, got %h", want.exponent, exponent_out);
          error_count++;
        end
        if (fraction_out !== want.fraction) begin
          $error("fraction_out: expected %h, got %h", want.fraction, fraction_out);
          error_count++;
        end
        if (quad_low_fill !== want.low_fill) begin
          $error("quad_low_fill: expected %0b, got %0b", want.low_fill, quad_low_fill);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    dir_row_t    row;
    out_word_t   want;
    op_t         op;
    logic [14:0] e;
    logic [63:0] sig;
    int          tb_bias;
    int          e_int;
    int          pick;
    bit          smooth;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DirCount; i++) begin
      row = DirectedRows[i];
      want = row.typed ? row.res : convert_extended(row.op, row.sgn, row.exp, row.sig);
      send_word(row.op, row.sgn, row.exp, row.sig, want);
      idle_sender(1'b0);
    end
    wait_until_drained();

    // random words, mostly well-formed values near each format's range
    smooth = 1'b0;
    for (int i = 0; i < ItemCount - DirCount; i++) begin
      if (i % 64 == 0) smooth = ($urandom_range(0, 3) == 0);
      if (i == 500) wait_until_drained();
      pick = $urandom_range(0, 15);
      op = (pick < 5) ? OP_SINGLE : (pick < 10) ? OP_DOUBLE : (pick < 15) ? OP_QUAD : OP_RSVD;
      tb_bias = (op == OP_SINGLE) ? 127 : (op == OP_DOUBLE) ? 1023 : 16383;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        e = ExpAllOnes;
      end else if (pick == 1) begin
        e = '0;
      end else if (pick == 2) begin
        e = 15'($urandom_range(0, 70));
      end else if (pick < 5) begin
        e = 15'($urandom);
      end else begin
        e_int = 16383 - tb_bias - 40 + int'($urandom_range(0, 2 * tb_bias + 80));
        e = e_int[14:0];
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        sig = '0;
      end else if (pick == 1) begin
        sig = '1;
      end else if (pick == 2) begin
        sig = 64'h8000_0000_0000_0000;
      end else if (pick < 7) begin
        sig = {$urandom, $urandom} >> $urandom_range(0, 63);
      end else begin
        sig = {$urandom, $urandom};
        sig[63] = 1'b1;
      end
      want = convert_extended(op, $urandom_range(0, 1) == 1, e, sig);
      send_word(op, want.sign, e, sig, want);
      idle_sender(smooth);
    end

    // drain and let the pipe settle
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: extended_to_ieee_format_convert.f
src/e2i_pkg.sv
src/e2i_lzc_stage.sv
src/e2i_shift_stage.sv
src/e2i_pack_stage.sv
src/extended_to_ieee_format_convert.sv
src/e2i_checker.sv
tb/extended_to_ieee_format_convert_tb.sv
